[hdl/fbm_value_noise_generator_macros.svh]
// ----------------------------------------------------------------------------
// fbm value noise generator assertion macros
// Shared concurrent assertion forms, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef FBM_VALUE_NOISE_GENERATOR_MACROS_SVH
`define FBM_VALUE_NOISE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// consequent checked in the same cycle
`define FBM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbm value noise: same cycle check failed");
// consequent checked in the next cycle
`define FBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbm value noise: next cycle check failed");
`else
`define FBM_ASSERT_SAME(label, clk, rst, ante, cons)
`define FBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/fbmvn_pkg.sv]
// ----------------------------------------------------------------------------
// fbmvn_pkg
// Widths, constants, register indexes and shared types of the value noise
// generator.
// ----------------------------------------------------------------------------
package fbmvn_pkg;

   // field widths
   localparam int GRID_W     = 12;
   localparam int FREQ_W     = 32;
   localparam int AMP_W      = 24;
   localparam int FACTOR_W   = 24;
   localparam int DIM_W      = 13;
   localparam int OCT_CNT_W  = 4;
   localparam int SEED_W     = 32;
   localparam int OUT_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // defaults and limits
   localparam int DEF_MAX_OCTAVES = 8;
   localparam int MAX_GRID_DIM    = 4096;

   // long division of grid times frequency by map size minus one
   localparam int DIV_STEPS  = 8;
   localparam int DIV_STAGES = (GRID_W + FREQ_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QUO_W      = DIV_STAGES * DIV_STEPS;

   // noise datapath widths
   localparam int FRAC_W   = 16;
   localparam int CELL_W   = 32;
   localparam int RAMP_W   = FRAC_W + 2;
   localparam int SMOOTH_W = FRAC_W + 1;
   localparam int NOISE_W  = 24;
   localparam int EX_W     = NOISE_W + 1 + SMOOTH_W + 1;
   localparam int LERP_W   = NOISE_W + 2;
   localparam int E2_W     = LERP_W + SMOOTH_W + 1;
   localparam int VAL_W    = NOISE_W + 2;
   localparam int PR_W     = VAL_W + AMP_W;
   localparam int TERM_W   = PR_W - NOISE_W;

   localparam logic [RAMP_W-1:0]        RAMP_THREE = RAMP_W'(3 * 65536);
   localparam logic signed [VAL_W-1:0]  VAL_HALF   = VAL_W'(1 << NOISE_W);
   localparam logic [FREQ_W-1:0]        FREQ_ONE   = FREQ_W'(65536);

   // lattice hash
   localparam logic [31:0] HASH_MX   = 32'd374761393;
   localparam logic [31:0] HASH_MZ   = 32'd668265263;
   localparam logic [31:0] HASH_MS   = 32'd2246822519;
   localparam logic [31:0] HASH_MF   = 32'd1274126177;
   localparam logic [31:0] SEED_STEP = 32'd1013;

   // pipeline stage numbers
   localparam int ST_MUL      = 1;
   localparam int ST_DIV0     = 2;
   localparam int ST_SMOOTH   = ST_DIV0 + DIV_STAGES;
   localparam int ST_HASH     = ST_SMOOTH + 1;
   localparam int ST_NOISE    = ST_HASH + 1;
   localparam int ST_LERPX_MUL = ST_NOISE + 1;
   localparam int ST_LERPX    = ST_LERPX_MUL + 1;
   localparam int ST_LERPZ_MUL = ST_LERPX + 1;
   localparam int ST_VALUE    = ST_LERPZ_MUL + 1;
   localparam int ST_TERM     = ST_VALUE + 1;
   localparam int NUM_STAGES  = ST_TERM + 1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NOISE_SEED     = 4'd0,
      REG_OCTAVE_COUNT   = 4'd1,
      REG_BASE_FREQUENCY = 4'd2,
      REG_BASE_AMPLITUDE = 4'd3,
      REG_LACUNARITY     = 4'd4,
      REG_OCTAVE_GAIN    = 4'd5,
      REG_MAP_WIDTH      = 4'd6,
      REG_MAP_HEIGHT     = 4'd7
   } csr_reg_type;

   // per octave settings handed to a lane
   typedef struct packed {
      logic [FREQ_W-1:0]       freq;
      logic [31:0]             seed_mix;
      logic signed [AMP_W-1:0] amp;
      logic                    active;
   } lane_cfg_type;

   // divisors shared by all lanes
   typedef struct packed {
      logic [DIM_W-1:0] div_x;
      logic [DIM_W-1:0] div_z;
   } dim_cfg_type;

   // partial remainder and dividend/quotient word
   typedef struct packed {
      logic [DIM_W-1:0] rem;
      logic [QUO_W-1:0] work;
   } div_state_type;

   // eight restoring division steps
   function automatic div_state_type div_steps(div_state_type st, logic [DIM_W-1:0] dvs);
      logic [DIM_W:0] t;
      div_state_type  r;
      r = st;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {r.rem, r.work[QUO_W-1]};
         r.work = {r.work[QUO_W-2:0], 1'b0};
         if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            r.work[0] = 1'b1;
         end
         r.rem = t[DIM_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/fbmvn_lane.sv]
// ----------------------------------------------------------------------------
// fbmvn_lane
// One octave of value noise: scaled coordinate, long division, smoothstep,
// corner hash, bilinear blend and amplitude weighting, each in its own stages.
// ----------------------------------------------------------------------------
module fbmvn_lane
   import fbmvn_pkg::*;
(
   input  logic                     clock,
   input  logic [ST_TERM:1]         adv,
   input  logic [GRID_W-1:0]        grid_x,
   input  logic [GRID_W-1:0]        grid_z,
   input  lane_cfg_type             lane_cfg,
   input  dim_cfg_type              dim_cfg,
   output logic signed [TERM_W-1:0] term
);

   logic [GRID_W-1:0]        grid [2];
   logic [DIM_W-1:0]         dvs [2];
   logic [QUO_W-1:0]         prod_in [2];
   logic [QUO_W-1:0]         prod_ff [2];
   div_state_type            first_st [2];
   div_state_type            div_in [DIV_STAGES][2];
   div_state_type            div_ff [DIV_STAGES][2];
   logic [FRAC_W-1:0]        sq_in [2];
   logic [FRAC_W-1:0]        sq_ff [2];
   logic [RAMP_W-1:0]        ramp_in [2];
   logic [RAMP_W-1:0]        ramp_ff [2];
   logic [31:0]              cm_in [2];
   logic [31:0]              cm_ff [2];
   logic [SMOOTH_W-1:0]      s_in [2];
   logic [SMOOTH_W-1:0]      s_ff [2];
   logic [31:0]              hm_in [4];
   logic [31:0]              hm_ff [4];
   logic [NOISE_W-1:0]       n_in [4];
   logic [NOISE_W-1:0]       n_ff [4];
   logic [SMOOTH_W-1:0]      s10_ff [2];
   logic signed [EX_W-1:0]   ex_in [2];
   logic signed [EX_W-1:0]   ex_ff [2];
   logic [NOISE_W-1:0]       base_ff [2];
   logic [SMOOTH_W-1:0]      sz11_ff;
   logic signed [LERP_W-1:0] l_in [2];
   logic signed [LERP_W-1:0] l_ff [2];
   logic [SMOOTH_W-1:0]      sz12_ff;
   logic signed [E2_W-1:0]   e2_in;
   logic signed [E2_W-1:0]   e2_ff;
   logic signed [LERP_W-1:0] l0_ff;
   logic signed [VAL_W-1:0]  v_in;
   logic signed [VAL_W-1:0]  v_ff;
   logic signed [TERM_W-1:0] term_in;
   logic signed [TERM_W-1:0] term_ff;

   assign grid[0] = grid_x;
   assign grid[1] = grid_z;
   assign dvs[0]  = dim_cfg.div_x;
   assign dvs[1]  = dim_cfg.div_z;

   // scaled coordinate and long division
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         prod_in[a]       = QUO_W'(grid[a] * lane_cfg.freq);
         first_st[a].rem  = '0;
         first_st[a].work = prod_ff[a];
         div_in[0][a]     = div_steps(first_st[a], dvs[a]);
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         for (int a = 0; a < 2; a++) begin
            div_in[k][a] = div_steps(div_ff[k-1][a], dvs[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         prod_ff <= prod_in;
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv[ST_DIV0 + k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // smoothstep square and ramp, hash row and column products
   always_comb begin
      logic [CELL_W-1:0]   lat_idx;
      logic [FRAC_W-1:0]   frac;
      logic [2*FRAC_W-1:0] fsq;
      for (int a = 0; a < 2; a++) begin
         lat_idx = div_ff[DIV_STAGES-1][a].work[FRAC_W+CELL_W-1:FRAC_W];
         frac = div_ff[DIV_STAGES-1][a].work[FRAC_W-1:0];
         fsq  = frac * frac;
         sq_in[a]   = fsq[2*FRAC_W-1:FRAC_W];
         ramp_in[a] = RAMP_THREE - RAMP_W'({frac, 1'b0});
         cm_in[a]   = lat_idx * ((a == 0) ? HASH_MX : HASH_MZ);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SMOOTH]) begin
         sq_ff   <= sq_in;
         ramp_ff <= ramp_in;
         cm_ff   <= cm_in;
      end
   end

   // smoothstep weight and corner hash mixing
   always_comb begin
      logic [FRAC_W+RAMP_W-1:0] sp;
      logic [31:0]              h;
      for (int a = 0; a < 2; a++) begin
         sp      = sq_ff[a] * ramp_ff[a];
         s_in[a] = sp[FRAC_W+RAMP_W-2:FRAC_W];
      end
      for (int c = 0; c < 4; c++) begin
         h = cm_ff[0] + (((c % 2) != 0) ? HASH_MX : 32'd0)
           + cm_ff[1] + (((c / 2) != 0) ? HASH_MZ : 32'd0)
           + lane_cfg.seed_mix;
         hm_in[c] = h ^ (h >> 13);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_HASH]) begin
         s_ff  <= s_in;
         hm_ff <= hm_in;
      end
   end

   // final hash multiply, 24-bit fraction per corner
   always_comb begin
      logic [31:0] hp;
      for (int c = 0; c < 4; c++) begin
         hp      = hm_ff[c] * HASH_MF;
         n_in[c] = hp[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_NOISE]) begin
         n_ff   <= n_in;
         s10_ff <= s_ff;
      end
   end

   // blend along x, product part
   always_comb begin
      logic signed [NOISE_W:0] dn;
      for (int r = 0; r < 2; r++) begin
         dn       = $signed({1'b0, n_ff[2*r+1]}) - $signed({1'b0, n_ff[2*r]});
         ex_in[r] = dn * $signed({1'b0, s10_ff[0]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_LERPX_MUL]) begin
         ex_ff      <= ex_in;
         base_ff[0] <= n_ff[0];
         base_ff[1] <= n_ff[2];
         sz11_ff    <= s10_ff[1];
      end
   end

   // blend along x, floor and add
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         l_in[r] = LERP_W'($signed({2'b00, base_ff[r]}) + $signed(ex_ff[r][EX_W-1:FRAC_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_LERPX]) begin
         l_ff    <= l_in;
         sz12_ff <= sz11_ff;
      end
   end

   // blend along z, product part
   assign e2_in = (l_ff[1] - l_ff[0]) * $signed({1'b0, sz12_ff});

   always_ff @(posedge clock) begin
      if (adv[ST_LERPZ_MUL]) begin
         e2_ff <= e2_in;
         l0_ff <= l_ff[0];
      end
   end

   // map to -1..1 in Q1.24
   always_comb begin
      logic signed [LERP_W-1:0] nv;
      nv   = LERP_W'(l0_ff + $signed(e2_ff[E2_W-1:FRAC_W]));
      v_in = (nv <<< 1) - VAL_HALF;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_VALUE]) begin
         v_ff <= v_in;
      end
   end

   // amplitude weighting, idle octaves give zero
   always_comb begin
      logic signed [PR_W-1:0] pr;
      pr      = v_ff * $signed(lane_cfg.amp);
      term_in = lane_cfg.active ? $signed(pr[PR_W-1:NOISE_W]) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_TERM]) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

[hdl/fbm_value_noise_generator.sv]
// ----------------------------------------------------------------------------
// fbm_value_noise_generator
// Fractal value noise height for one grid coordinate per word, summed over up
// to MAX_OCTAVES octaves in parallel lanes.
// ----------------------------------------------------------------------------
// A request word (grid_x, grid_z) is taken each cycle the request side does
// not stall; its noise_height word leaves from the last stage. Per stage
// valid bits let bubbles close up, so outside the settle window the request
// side stalls only when the pipeline is full behind a stalled response.
// Each octave has its own lane, and its division by map size minus one is
// a 48-step long division spread over six stages of eight steps. Frequency
// and amplitude per octave come from a chain of one register per octave,
// the seed mix from the seed register; after reset and after every write
// the request side stalls while that chain settles. The user writes
// registers one word per cycle, only when idle; the block does not enforce it.
`include "fbm_value_noise_generator_macros.svh"

module fbm_value_noise_generator
   import fbmvn_pkg::*;
#(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
   input  logic                  clock,
   input  logic                  reset,
   // request words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [GRID_W-1:0]     req_grid_x,
   input  logic [GRID_W-1:0]     req_grid_z,
   // response words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [OUT_W-1:0] rsp_noise_height,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W      = OCT_CNT_W + 1;
   localparam int SETTLE_CYC = MAX_OCTAVES + 1;
   localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

   // registers
   logic [SEED_W-1:0]       seed_ff;
   logic [OCT_CNT_W-1:0]    oct_ff;
   logic [FREQ_W-1:0]       bfreq_ff;
   logic signed [AMP_W-1:0] bamp_ff;
   logic [FACTOR_W-1:0]     lac_ff;
   logic [FACTOR_W-1:0]     gain_ff;
   logic [DIM_W-1:0]        mapw_ff;
   logic [DIM_W-1:0]        maph_ff;

   logic                    csr_write;
   logic [SETTLE_W-1:0]     settle_in;
   logic [SETTLE_W-1:0]     settle_ff;

   // derived per octave settings
   logic [CNT_W-1:0]        cnt;
   logic [FREQ_W-1:0]       freq_ff [MAX_OCTAVES];
   logic signed [AMP_W-1:0] amp_ff [MAX_OCTAVES];
   logic [31:0]             seed_mix_ff [MAX_OCTAVES];
   logic                    active_ff [MAX_OCTAVES];
   dim_cfg_type             dim_in;
   dim_cfg_type             dim_ff;
   lane_cfg_type            lane_cfg [MAX_OCTAVES];

   // pipeline control
   logic [NUM_STAGES:1]     adv;
   logic [NUM_STAGES:1]     v_ff;
   logic                    req_accept;

   // lane results and sum
   logic signed [TERM_W-1:0] term [MAX_OCTAVES];
   logic signed [OUT_W-1:0]  sum_in;
   logic signed [OUT_W-1:0]  sum_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         oct_ff   <= OCT_CNT_W'(1);
         bfreq_ff <= FREQ_ONE;
         bamp_ff  <= AMP_W'(65536);
         lac_ff   <= FACTOR_W'(131072);
         gain_ff  <= FACTOR_W'(32768);
         mapw_ff  <= DIM_W'(256);
         maph_ff  <= DIM_W'(256);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_NOISE_SEED:     seed_ff  <= csr_wdata[SEED_W-1:0];
            REG_OCTAVE_COUNT:   oct_ff   <= csr_wdata[OCT_CNT_W-1:0];
            REG_BASE_FREQUENCY: bfreq_ff <= csr_wdata[FREQ_W-1:0];
            REG_BASE_AMPLITUDE: bamp_ff  <= $signed(csr_wdata[AMP_W-1:0]);
            REG_LACUNARITY:     lac_ff   <= csr_wdata[FACTOR_W-1:0];
            REG_OCTAVE_GAIN:    gain_ff  <= csr_wdata[FACTOR_W-1:0];
            REG_MAP_WIDTH:      mapw_ff  <= csr_wdata[DIM_W-1:0];
            REG_MAP_HEIGHT:     maph_ff  <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // settle window after reset or a write
   always_comb begin
      priority if (csr_write) begin
         settle_in = SETTLE_W'(SETTLE_CYC);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_W'(SETTLE_CYC);
      end else begin
         settle_ff <= settle_in;
      end
   end

   // clamped octave count and divisors
   always_comb begin
      priority if (oct_ff == '0) begin
         cnt = CNT_W'(1);
      end else if (CNT_W'(oct_ff) > CNT_W'(MAX_OCTAVES)) begin
         cnt = CNT_W'(MAX_OCTAVES);
      end else begin
         cnt = CNT_W'(oct_ff);
      end
      priority if (mapw_ff < DIM_W'(2)) begin
         dim_in.div_x = DIM_W'(1);
      end else if (mapw_ff > DIM_W'(MAX_GRID_DIM)) begin
         dim_in.div_x = DIM_W'(MAX_GRID_DIM - 1);
      end else begin
         dim_in.div_x = mapw_ff - DIM_W'(1);
      end
      priority if (maph_ff < DIM_W'(2)) begin
         dim_in.div_z = DIM_W'(1);
      end else if (maph_ff > DIM_W'(MAX_GRID_DIM)) begin
         dim_in.div_z = DIM_W'(MAX_GRID_DIM - 1);
      end else begin
         dim_in.div_z = maph_ff - DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dim_ff <= dim_in;
   end

   // frequency and amplitude chain, one octave per register, and seed mix per octave
   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      always_ff @(posedge clock) begin
         seed_mix_ff[o] <= (seed_ff + 32'(o) * SEED_STEP) * HASH_MS;
         active_ff[o]   <= CNT_W'(o) < cnt;
      end

      if (o == 0) begin : g_first
         always_ff @(posedge clock) begin
            freq_ff[o] <= (bfreq_ff == '0) ? FREQ_ONE : bfreq_ff;
            amp_ff[o]  <= bamp_ff;
         end
      end else begin : g_next
         logic [FREQ_W+FACTOR_W-1:0]   fp;
         logic signed [AMP_W+FACTOR_W:0] ap;
         logic signed [AMP_W+FACTOR_W-FRAC_W:0] as;
         logic [FREQ_W-1:0]            freq_in;
         logic signed [AMP_W-1:0]      amp_in;

         always_comb begin
            fp = freq_ff[o-1] * lac_ff;
            if (fp[FREQ_W+FACTOR_W-1:FREQ_W+FRAC_W] != '0) begin
               freq_in = '1;
            end else begin
               freq_in = fp[FREQ_W+FRAC_W-1:FRAC_W];
            end
            ap = amp_ff[o-1] * $signed({1'b0, gain_ff});
            as = ap[AMP_W+FACTOR_W:FRAC_W];
            priority if (as > $signed((AMP_W+FACTOR_W-FRAC_W+1)'((1 << (AMP_W-1)) - 1))) begin
               amp_in = {1'b0, {(AMP_W-1){1'b1}}};
            end else if (as < -$signed((AMP_W+FACTOR_W-FRAC_W+1)'(1 << (AMP_W-1)))) begin
               amp_in = {1'b1, {(AMP_W-1){1'b0}}};
            end else begin
               amp_in = as[AMP_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            freq_ff[o] <= freq_in;
            amp_ff[o]  <= amp_in;
         end
      end

      assign lane_cfg[o].freq     = freq_ff[o];
      assign lane_cfg[o].seed_mix = seed_mix_ff[o];
      assign lane_cfg[o].amp      = amp_ff[o];
      assign lane_cfg[o].active   = active_ff[o];

      fbmvn_lane u_lane (
         .clock    (clock),
         .adv      (adv[ST_TERM:1]),
         .grid_x   (req_grid_x),
         .grid_z   (req_grid_z),
         .lane_cfg (lane_cfg[o]),
         .dim_cfg  (dim_ff),
         .term     (term[o])
      );
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      adv[NUM_STAGES] = !v_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_stall  = !adv[1] || (settle_ff != '0);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_accept;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // octave sum, cannot leave the output range
   always_comb begin
      sum_in = '0;
      for (int o = 0; o < MAX_OCTAVES; o++) begin
         sum_in = sum_in + OUT_W'(term[o]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES]) begin
         sum_ff <= sum_in;
      end
   end

   assign rsp_valid        = v_ff[NUM_STAGES];
   assign rsp_noise_height = sum_ff;

   // a register write closes the request side for the settle window
   `FBM_ASSERT_NEXT(a_write_stalls_req, clock, reset, csr_write, req_stall)
   // a response word only appears out of the stage before it
   `FBM_ASSERT_SAME(a_rsp_from_prev, clock, reset, $rose(v_ff[NUM_STAGES]), $past(v_ff[NUM_STAGES-1]))
   // an accepted request word occupies the first stage
   `FBM_ASSERT_NEXT(a_accept_enters, clock, reset, req_accept, v_ff[1])

endmodule
